@@ hdl/cslot_pkg.sv @@
// Package: shared types and constants of the complex slot register file.
package cslot_pkg;
    localparam int SlotCount = 1024;
    localparam int SlotBits  = $clog2(SlotCount);
    localparam int NumBits   = $clog2(SlotCount + 1);

    typedef enum logic [3:0] {
        OP_LOAD = 4'd0, OP_ADD = 4'd1, OP_DELETE = 4'd2, OP_NUMBER = 4'd3,
        OP_ARITH = 4'd4, OP_COUNT = 4'd5, OP_QUAD = 4'd6, OP_CONJ = 4'd7,
        OP_ROTATE = 4'd8
    } t_op;

    localparam logic [2:0] ST_VALUE    = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_OCCUPIED = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_NUMBER   = 3'd6;
    localparam logic [2:0] ST_NOQUAD   = 3'd7;

    localparam logic [1:0] KIND_SUM  = 2'd0;
    localparam logic [1:0] KIND_DIFF = 2'd1;

    localparam logic [3:0] RegSlotsInUse = 4'd0;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_T, S_WT_T, S_RD_L, S_RD_R,
        S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_EXEC, S_SCAN, S_SCAN_END, S_OUT
    } t_state;

    function automatic logic [2:0] quadrant_of(input logic [31:0] re, input logic [31:0] im);
        logic rp, rn, ip, in_n;
        rp = (re != 32'd0) && !re[31];
        rn = re[31];
        ip = (im != 32'd0) && !im[31];
        in_n = im[31];
        if (rp && ip)        quadrant_of = 3'd1;
        else if (rn && ip)   quadrant_of = 3'd2;
        else if (rn && in_n) quadrant_of = 3'd3;
        else if (rp && in_n) quadrant_of = 3'd4;
        else                 quadrant_of = 3'd0;
    endfunction
endpackage

@@ hdl/cslot_ram.sv @@
// Generic single-port RAM with registered read.
module cslot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ hdl/complex_slot_register_file_unit.sv @@
// Top level: complex slot register file with command sequencer.
//
// A table of 1024 slots, each a wrapping 32-bit complex integer plus a valid
// mark. One command is taken over the tdata stream and, for every command
// but load, one result transfer follows. The block runs one command at a
// time: s_axis_tready is high only while idle. The single-slot commands
// read the slot, then write it back where needed; number reads no slot.
// Arith reads target, left and right slot in turn, then ends with a status
// when an operand slot is empty or the destination full, or else forms a
// sum, difference or complex product; the four partial products share one
// 32x32 multiplier. The quadrant count reads one slot a cycle up to
// slots_in_use, which saturates at 1024. A stall by the receiver holds off
// the next command until the result is taken.
// Slot values and valid marks live in RAM; the occupancy count is a register.
// After reset a clearing pass writes every valid mark to zero, one a cycle,
// and holds the input off until it is done.
// s_axis_tdata (lowest bit up): op[3:0], target_slot[13:4], left_slot[23:14],
// right_slot[33:24], real_in[65:34], imag_in[97:66], arith_kind[99:98],
// quadrant_sel[102:100], clockwise[103].
// m_axis_tdata (lowest bit up): status[2:0], real_out[34:3], imag_out[66:35],
// number_out[77:67]. APB register 0 at address 0: slots_in_use.
module complex_slot_register_file_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,   // op,target,left,right,real,imag,kind,qsel,cw
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [79:0]   m_axis_tdata,   // status,real_out,imag_out,number_out
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int SB = cslot_pkg::SlotBits;
    localparam int NB = cslot_pkg::NumBits;

    cslot_pkg::t_state r_state, n_state;

    // Command fields held for the whole command
    logic [3:0]    r_op;
    logic [SB-1:0] r_t, r_l, r_r;
    logic [31:0]   r_re_in, r_im_in;
    logic [1:0]    r_kind;
    logic [2:0]    r_qsel;
    logic          r_cw;

    logic [31:0]   r_ar, r_ai, r_br, r_bi, r_acc_re, r_acc_im;
    logic [NB-1:0] r_occ, r_siu, r_cnt, r_idx;
    logic          r_scan_v, r_tv, r_lv;

    logic [2:0]    r_st;
    logic [31:0]   r_ro, r_io;
    logic [NB-1:0] r_no;
    logic          r_ovalid;

    // RAM port, shared address for values and valid marks
    logic          ram_we, vld_we;
    logic [SB-1:0] ram_addr;
    logic [31:0]   ram_wre, ram_wim, ram_rre, ram_rim;
    logic [0:0]    vld_wd, vld_rd;

    cslot_ram #(.WIDTH(32), .DEPTH(cslot_pkg::SlotCount)) u_re (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wre), .o_rdata(ram_rre));
    cslot_ram #(.WIDTH(32), .DEPTH(cslot_pkg::SlotCount)) u_im (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wim), .o_rdata(ram_rim));
    cslot_ram #(.WIDTH(1), .DEPTH(cslot_pkg::SlotCount)) u_vld (
        .i_clk(i_clk), .i_we(vld_we), .i_addr(ram_addr),
        .i_wdata(vld_wd), .o_rdata(vld_rd));

    // Shared multiplier
    logic [31:0] mul_a, mul_b, mul_p;
    assign mul_p = mul_a * mul_b;

    logic [NB-1:0] lim;
    assign lim = (r_siu > NB'(cslot_pkg::SlotCount)) ? NB'(cslot_pkg::SlotCount) : r_siu;

    assign pready        = 1'b1;
    assign prdata        = {{(32-NB){1'b0}}, r_siu};
    assign s_axis_tready = (r_state == cslot_pkg::S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(80-3-64-NB){1'b0}}, r_no, r_io, r_ro, r_st};

    // tv: valid mark of the slot read in the previous cycle
    logic in_fire, tv;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign tv      = vld_rd[0];

    // Result staged by the sequencer
    logic          emit;
    logic [2:0]    e_st;
    logic [31:0]   e_re, e_im;
    logic [NB-1:0] e_no;
    logic          occ_inc, occ_dec;
    logic [31:0]   rr, ri;

    always_comb begin
        n_state  = r_state;
        ram_we   = 1'b0;
        vld_we   = 1'b0;
        vld_wd   = 1'b1;
        ram_addr = r_t;
        ram_wre  = r_re_in;
        ram_wim  = r_im_in;
        mul_a    = r_ar;
        mul_b    = r_br;
        emit     = 1'b0;
        e_st     = cslot_pkg::ST_VALUE;
        e_re     = '0;
        e_im     = '0;
        e_no     = '0;
        occ_inc  = 1'b0;
        occ_dec  = 1'b0;
        rr       = '0;
        ri       = '0;
        unique case (r_state)
            cslot_pkg::S_CLEAR: begin
                // Drop every valid mark, one slot a cycle
                ram_addr = r_idx[SB-1:0];
                vld_we   = 1'b1;
                vld_wd   = 1'b0;
                if (r_idx == NB'(cslot_pkg::SlotCount - 1)) n_state = cslot_pkg::S_IDLE;
            end
            cslot_pkg::S_IDLE: begin
                if (in_fire) n_state = cslot_pkg::S_RD_T;
            end
            cslot_pkg::S_RD_T: begin
                priority case (r_op)
                    cslot_pkg::OP_NUMBER: begin
                        emit = 1'b1; e_st = cslot_pkg::ST_NUMBER; e_no = r_occ;
                        n_state = cslot_pkg::S_OUT;
                    end
                    cslot_pkg::OP_COUNT: begin
                        ram_addr = '0; n_state = cslot_pkg::S_SCAN;
                    end
                    cslot_pkg::OP_LOAD, cslot_pkg::OP_ADD, cslot_pkg::OP_DELETE,
                    cslot_pkg::OP_ARITH, cslot_pkg::OP_QUAD, cslot_pkg::OP_CONJ,
                    cslot_pkg::OP_ROTATE: begin
                        n_state = cslot_pkg::S_WT_T;   // target slot being read
                    end
                    default: n_state = cslot_pkg::S_IDLE;
                endcase
            end
            cslot_pkg::S_WT_T: begin
                priority case (r_op)
                    cslot_pkg::OP_LOAD: begin
                        ram_we = 1'b1; vld_we = 1'b1; occ_inc = !tv;
                        n_state = cslot_pkg::S_IDLE;
                    end
                    cslot_pkg::OP_ADD: begin
                        emit = 1'b1;
                        if (tv) e_st = cslot_pkg::ST_OCCUPIED;
                        else begin
                            ram_we = 1'b1; vld_we = 1'b1; occ_inc = 1'b1;
                            e_st = cslot_pkg::ST_ADDED;
                        end
                        n_state = cslot_pkg::S_OUT;
                    end
                    cslot_pkg::OP_ARITH: begin
                        ram_addr = r_l; n_state = cslot_pkg::S_RD_L;
                    end
                    default: begin
                        emit = 1'b1;
                        n_state = cslot_pkg::S_OUT;
                        if (!tv) e_st = cslot_pkg::ST_EMPTY;
                        else begin
                            priority case (r_op)
                                cslot_pkg::OP_DELETE: begin
                                    vld_we = 1'b1; vld_wd = 1'b0; occ_dec = 1'b1;
                                    e_re = ram_rre; e_im = ram_rim;
                                end
                                cslot_pkg::OP_QUAD: begin
                                    e_no = NB'(cslot_pkg::quadrant_of(ram_rre, ram_rim));
                                    e_st = (e_no == '0) ? cslot_pkg::ST_NOQUAD
                                                        : cslot_pkg::ST_NUMBER;
                                end
                                cslot_pkg::OP_CONJ: begin
                                    e_re = ram_rre; e_im = 32'd0 - ram_rim;
                                end
                                default: begin
                                    if (r_cw) begin
                                        e_re = ram_rim; e_im = 32'd0 - ram_rre;
                                    end else begin
                                        e_re = 32'd0 - ram_rim; e_im = ram_rre;
                                    end
                                end
                            endcase
                            if (r_op != cslot_pkg::OP_DELETE && r_op != cslot_pkg::OP_QUAD) begin
                                ram_we = 1'b1; ram_wre = e_re; ram_wim = e_im;
                            end
                        end
                    end
                endcase
            end
            cslot_pkg::S_RD_L: begin
                ram_addr = r_r; n_state = cslot_pkg::S_RD_R;   // capture left
            end
            cslot_pkg::S_RD_R: begin
                // Right operand arrives now; missing operand outranks a full destination
                if (!r_lv || !tv) begin
                    emit = 1'b1; e_st = cslot_pkg::ST_MISSING;
                    n_state = cslot_pkg::S_OUT;
                end else if (r_tv) begin
                    emit = 1'b1; e_st = cslot_pkg::ST_FULL;
                    n_state = cslot_pkg::S_OUT;
                end else begin
                    n_state = (r_kind == cslot_pkg::KIND_SUM || r_kind == cslot_pkg::KIND_DIFF)
                        ? cslot_pkg::S_EXEC : cslot_pkg::S_MUL0;
                end
            end
            cslot_pkg::S_MUL0: begin
                mul_a = r_ar; mul_b = r_br; n_state = cslot_pkg::S_MUL1;
            end
            cslot_pkg::S_MUL1: begin
                mul_a = r_ai; mul_b = r_bi; n_state = cslot_pkg::S_MUL2;
            end
            cslot_pkg::S_MUL2: begin
                mul_a = r_ar; mul_b = r_bi; n_state = cslot_pkg::S_MUL3;
            end
            cslot_pkg::S_MUL3: begin
                mul_a = r_ai; mul_b = r_br; n_state = cslot_pkg::S_EXEC;
            end
            cslot_pkg::S_EXEC: begin
                if (r_kind == cslot_pkg::KIND_SUM) begin
                    rr = r_ar + r_br; ri = r_ai + r_bi;
                end else if (r_kind == cslot_pkg::KIND_DIFF) begin
                    rr = r_ar - r_br; ri = r_ai - r_bi;
                end else begin
                    rr = r_acc_re; ri = r_acc_im;
                end
                ram_we = 1'b1; ram_wre = rr; ram_wim = ri;
                vld_we = 1'b1; occ_inc = 1'b1;
                emit = 1'b1; e_re = rr; e_im = ri;
                n_state = cslot_pkg::S_OUT;
            end
            cslot_pkg::S_SCAN: begin
                // Address runs one ahead of the data being judged
                ram_addr = SB'(r_idx + NB'(1));
                if (r_idx + NB'(1) >= lim) n_state = cslot_pkg::S_SCAN_END;
            end
            cslot_pkg::S_SCAN_END: begin
                emit = 1'b1; e_st = cslot_pkg::ST_NUMBER; e_no = r_cnt;
                n_state = cslot_pkg::S_OUT;
            end
            cslot_pkg::S_OUT: begin
                if (!r_ovalid) n_state = cslot_pkg::S_IDLE;
            end
            default: n_state = cslot_pkg::S_IDLE;
        endcase
    end

    logic hit;
    assign hit = r_scan_v && tv && (r_qsel != 3'd0)
                 && (cslot_pkg::quadrant_of(ram_rre, ram_rim) == r_qsel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cslot_pkg::S_CLEAR;
            r_idx    <= '0;
            r_occ    <= '0;
            r_siu    <= NB'(cslot_pkg::SlotCount);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2:2] == cslot_pkg::RegSlotsInUse[0:0]
                && paddr[1:0] == 2'b00)
                r_siu <= pwdata[NB-1:0];
            if (occ_inc) r_occ <= r_occ + NB'(1);
            else if (occ_dec) r_occ <= r_occ - NB'(1);
            if (emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            // Index walks the clearing pass and the scan
            if (r_state == cslot_pkg::S_CLEAR || r_state == cslot_pkg::S_SCAN)
                r_idx <= r_idx + NB'(1);
            else if (r_state == cslot_pkg::S_RD_T && r_op == cslot_pkg::OP_COUNT)
                r_idx <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_axis_tdata[3:0];
            r_t     <= s_axis_tdata[4 +: SB];
            r_l     <= s_axis_tdata[14 +: SB];
            r_r     <= s_axis_tdata[24 +: SB];
            r_re_in <= s_axis_tdata[65:34];
            r_im_in <= s_axis_tdata[97:66];
            r_kind  <= s_axis_tdata[99:98];
            r_qsel  <= s_axis_tdata[102:100];
            r_cw    <= s_axis_tdata[103];
        end
        if (r_state == cslot_pkg::S_WT_T) r_tv <= tv;
        if (r_state == cslot_pkg::S_RD_L) begin
            r_ar <= ram_rre; r_ai <= ram_rim; r_lv <= tv;
        end
        if (r_state == cslot_pkg::S_RD_R) begin
            r_br <= ram_rre; r_bi <= ram_rim;
        end
        // Accumulate partial products into the result registers
        unique case (r_state)
            cslot_pkg::S_MUL0: r_acc_re <= mul_p;
            cslot_pkg::S_MUL1: r_acc_re <= r_acc_re - mul_p;
            cslot_pkg::S_MUL2: r_acc_im <= mul_p;
            cslot_pkg::S_MUL3: r_acc_im <= r_acc_im + mul_p;
            default: ;
        endcase
        // Scan: index points at the entry whose data arrives this cycle
        if (r_state == cslot_pkg::S_RD_T && r_op == cslot_pkg::OP_COUNT) begin
            r_cnt    <= '0;
            r_scan_v <= (lim != '0);
        end else if (r_state == cslot_pkg::S_SCAN) begin
            if (hit) r_cnt <= r_cnt + NB'(1);
            r_scan_v <= (r_idx + NB'(1) < lim);
        end
        if (emit) begin
            r_st <= e_st;
            r_ro <= e_re;
            r_io <= e_im;
            r_no <= e_no;
        end
    end
endmodule
